[src/tod_dly_pkg.sv]
// ---------------------------------------------------------------------------
// Time-of-day delay package
// Shared types and constants of the time-of-day delay calculator: time unit
// ratios, day residues for folding a 64-bit microsecond count, and the
// reciprocal constants used for the constant divisions.
// ---------------------------------------------------------------------------
package tod_dly_pkg;

  // Time unit ratios
  localparam logic [26:0] MS_PER_SEC  = 27'd1000;
  localparam logic [26:0] MS_PER_MIN  = 27'd60000;
  localparam logic [26:0] MS_PER_HOUR = 27'd3600000;
  localparam logic [26:0] MS_PER_DAY  = 27'd86400000;
  localparam logic [11:0] US_PER_MS   = 12'd1000;
  localparam logic [36:0] US_PER_DAY  = 37'd86400000000;

  // Saturation limits of the target fields
  localparam logic [4:0] HOUR_MAX  = 5'd23;
  localparam logic [5:0] MIN_MAX   = 6'd59;
  localparam logic [5:0] SEC_MAX   = 6'd59;
  localparam logic [9:0] MILLI_MAX = 10'd999;

  // Residues of the upper byte weights modulo one day in microseconds
  localparam logic [36:0] RES_B5 = 37'((64'd1 << 40) % 64'd86400000000);
  localparam logic [36:0] RES_B6 = 37'((64'd1 << 48) % 64'd86400000000);
  localparam logic [36:0] RES_B7 = 37'((64'd1 << 56) % 64'd86400000000);

  // Reciprocals for quotient estimates (estimate is low by a few at most)
  localparam logic [10:0] K_DAY  = 11'((64'd1 << 47) / 64'd86400000000);
  localparam logic [27:0] K_MS   = 28'((64'd1 << 37) / 64'd1000);
  localparam logic [17:0] K_SEC  = 18'((64'd1 << 27) / 64'd1000);
  localparam logic [11:0] K_MIN  = 12'((64'd1 << 27) / 64'd60000);
  localparam logic [5:0]  K_HOUR = 6'((64'd1 << 27) / 64'd3600000);

  // Highest specified target field
  typedef enum logic [2:0] {
    LVL_NONE = 3'd0,
    LVL_MS   = 3'd1,
    LVL_SEC  = 3'd2,
    LVL_MIN  = 3'd3,
    LVL_HOUR = 3'd4
  } level_t;

  // Per-beat data that rides alongside the timestamp reduction
  typedef struct packed {
    level_t      level;
    logic [26:0] tsum;
  } side_t;

endpackage

[src/time_of_day_delay_calc.sv]
// ---------------------------------------------------------------------------
// Time-of-day delay calculator
// Reduces a UTC microsecond timestamp to the position within the day and
// returns the milliseconds until the next moment that matches the target
// hour, minute, second and millisecond from the highest given field down.
// ---------------------------------------------------------------------------
// Throughput: one beat per cycle; the ten-stage pipeline (input register,
// eight arithmetic stages, output register) advances as a whole whenever
// the output register is empty or its beat is taken.
// Reset: clears the stage valid bits and the output valid; data registers
// are not reset.
module time_of_day_delay_calc (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        now_us,
  input  logic signed [5:0]  target_hour,
  input  logic signed [6:0]  target_minute,
  input  logic signed [6:0]  target_second,
  input  logic signed [10:0] target_milli,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [26:0]        delay_ms
);

  localparam int NSTG = 9;

  logic                    adv;
  logic [NSTG-1:0]         vld;
  tod_dly_pkg::side_t      side [NSTG];

  logic [4:0]              hr_val;
  logic [5:0]              min_val;
  logic [5:0]              sec_val;
  logic [9:0]              mil_val;
  tod_dly_pkg::level_t     lvl_in;
  logic [26:0]             tsum_in;

  logic [63:0]             s0_now;
  logic [46:0]             a_y;
  logic [46:0]             a_y_next;
  logic [46:0]             b_y;
  logic [10:0]             b_qd;
  logic [31:0]             b_prod;
  logic [46:0]             c_diff;
  logic [37:0]             c_r;
  logic [36:0]             d_us;
  logic [36:0]             d_us_next;
  logic [36:0]             e_us;
  logic [26:0]             e_q;
  logic [54:0]             e_prod;
  logic [11:0]             f_mul;
  logic [11:0]             f_rem;
  logic [1:0]              f_corr;
  logic [26:0]             f_ms;
  logic [44:0]             g_p1;
  logic [38:0]             g_p2;
  logic [32:0]             g_p3;
  logic [10:0]             g_q1;
  logic [10:0]             g_q2;
  logic [4:0]              g_q3;
  logic [26:0]             g_ms;
  logic [10:0]             h_r1;
  logic [16:0]             h_r2;
  logic [22:0]             h_r3;
  logic [9:0]              h_c1;
  logic [15:0]             h_c2;
  logic [21:0]             h_c3;
  logic [26:0]             h_c4;
  logic [26:0]             o_cur;
  logic [26:0]             o_per;
  logic [27:0]             o_diff;
  logic [26:0]             delay_next;

  // Advance the whole pipeline when the output register can take a beat
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Decode targets: negative means not given, above range saturates
  always_comb begin
    hr_val  = '0;
    min_val = '0;
    sec_val = '0;
    mil_val = '0;
    if (!target_hour[5]) begin
      hr_val = (target_hour[4:0] > tod_dly_pkg::HOUR_MAX) ? tod_dly_pkg::HOUR_MAX
                                                          : target_hour[4:0];
    end
    if (!target_minute[6]) begin
      min_val = (target_minute[5:0] > tod_dly_pkg::MIN_MAX) ? tod_dly_pkg::MIN_MAX
                                                            : target_minute[5:0];
    end
    if (!target_second[6]) begin
      sec_val = (target_second[5:0] > tod_dly_pkg::SEC_MAX) ? tod_dly_pkg::SEC_MAX
                                                            : target_second[5:0];
    end
    if (!target_milli[10]) begin
      mil_val = (target_milli[9:0] > tod_dly_pkg::MILLI_MAX) ? tod_dly_pkg::MILLI_MAX
                                                             : target_milli[9:0];
    end
  end

  // Pick the highest given field
  always_comb begin
    priority if (!target_hour[5]) begin
      lvl_in = tod_dly_pkg::LVL_HOUR;
    end else if (!target_minute[6]) begin
      lvl_in = tod_dly_pkg::LVL_MIN;
    end else if (!target_second[6]) begin
      lvl_in = tod_dly_pkg::LVL_SEC;
    end else if (!target_milli[10]) begin
      lvl_in = tod_dly_pkg::LVL_MS;
    end else begin
      lvl_in = tod_dly_pkg::LVL_NONE;
    end
  end

  // Weight the target; fields not given decode to zero
  assign tsum_in = 27'(hr_val) * tod_dly_pkg::MS_PER_HOUR
                 + 27'(min_val) * tod_dly_pkg::MS_PER_MIN
                 + 27'(sec_val) * tod_dly_pkg::MS_PER_SEC
                 + 27'(mil_val);

  // Fold the upper bytes of the timestamp by their day residues
  assign a_y_next = 47'(s0_now[39:0])
                  + 47'(s0_now[47:40]) * 47'(tod_dly_pkg::RES_B5)
                  + 47'(s0_now[55:48]) * 47'(tod_dly_pkg::RES_B6)
                  + 47'(s0_now[63:56]) * 47'(tod_dly_pkg::RES_B7);

  // Estimate the day count, low by at most two
  assign b_prod = 32'(a_y[46:26]) * 32'(tod_dly_pkg::K_DAY);

  // Subtract the estimated whole days
  assign c_diff = b_y - 47'(b_qd) * 47'(tod_dly_pkg::US_PER_DAY);

  // Correct the remainder into one day
  always_comb begin
    priority if (c_r >= 38'(2 * 38'(tod_dly_pkg::US_PER_DAY))) begin
      d_us_next = 37'(c_r - 38'(2 * 38'(tod_dly_pkg::US_PER_DAY)));
    end else if (c_r >= 38'(tod_dly_pkg::US_PER_DAY)) begin
      d_us_next = 37'(c_r - 38'(tod_dly_pkg::US_PER_DAY));
    end else begin
      d_us_next = c_r[36:0];
    end
  end

  // Estimate milliseconds of the day, low by at most three
  assign e_prod = 55'(d_us[36:10]) * 55'(tod_dly_pkg::K_MS);

  // Fix the millisecond estimate from the low bits of the remainder
  assign f_mul = e_q[11:0] * tod_dly_pkg::US_PER_MS;
  assign f_rem = e_us[11:0] - f_mul;

  always_comb begin
    priority if (f_rem >= 12'(3 * tod_dly_pkg::US_PER_MS)) begin
      f_corr = 2'd3;
    end else if (f_rem >= 12'(2 * tod_dly_pkg::US_PER_MS)) begin
      f_corr = 2'd2;
    end else if (f_rem >= tod_dly_pkg::US_PER_MS) begin
      f_corr = 2'd1;
    end else begin
      f_corr = 2'd0;
    end
  end

  // Estimate whole seconds, minutes and hours, each low by at most one
  assign g_p1 = 45'(f_ms) * 45'(tod_dly_pkg::K_SEC);
  assign g_p2 = 39'(f_ms) * 39'(tod_dly_pkg::K_MIN);
  assign g_p3 = 33'(f_ms) * 33'(tod_dly_pkg::K_HOUR);

  // Take remainders within second, minute and hour from the low bits
  assign h_r1 = g_ms[10:0] - g_q1 * 11'(tod_dly_pkg::MS_PER_SEC);
  assign h_r2 = g_ms[16:0] - 17'(g_q2) * 17'(tod_dly_pkg::MS_PER_MIN);
  assign h_r3 = g_ms[22:0] - 23'(g_q3) * 23'(tod_dly_pkg::MS_PER_HOUR);

  // Select the current position and period of the highest given field
  always_comb begin
    unique case (side[NSTG-1].level)
      tod_dly_pkg::LVL_HOUR: begin
        o_cur = h_c4;
        o_per = tod_dly_pkg::MS_PER_DAY;
      end
      tod_dly_pkg::LVL_MIN: begin
        o_cur = 27'(h_c3);
        o_per = tod_dly_pkg::MS_PER_HOUR;
      end
      tod_dly_pkg::LVL_SEC: begin
        o_cur = 27'(h_c2);
        o_per = tod_dly_pkg::MS_PER_MIN;
      end
      tod_dly_pkg::LVL_MS: begin
        o_cur = 27'(h_c1);
        o_per = tod_dly_pkg::MS_PER_SEC;
      end
      default: begin
        o_cur = '0;
        o_per = '0;
      end
    endcase
  end

  // Wrap a negative difference by one period
  assign o_diff     = {1'b0, side[NSTG-1].tsum} - {1'b0, o_cur};
  assign delay_next = o_diff[27] ? (o_diff[26:0] + o_per) : o_diff[26:0];

  // Shift valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[NSTG-2:0], in_valid};
      out_valid <= vld[NSTG-1];
    end
  end

  // Advance data registers; hold everything while the output is blocked
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_now       <= now_us;
      side[0]      <= '{level: lvl_in, tsum: tsum_in};
      for (int i = 1; i < NSTG; i++) begin
        side[i] <= side[i-1];
      end
      a_y          <= a_y_next;
      b_y          <= a_y;
      b_qd         <= b_prod[31:21];
      c_r          <= c_diff[37:0];
      d_us         <= d_us_next;
      e_us         <= d_us;
      e_q          <= e_prod[53:27];
      f_ms         <= e_q + 27'(f_corr);
      g_ms         <= f_ms;
      g_q1         <= g_p1[37:27];
      g_q2         <= g_p2[37:27];
      g_q3         <= g_p3[31:27];
      h_c1         <= (h_r1 >= 11'(tod_dly_pkg::MS_PER_SEC))
                      ? 10'(h_r1 - 11'(tod_dly_pkg::MS_PER_SEC)) : h_r1[9:0];
      h_c2         <= (h_r2 >= 17'(tod_dly_pkg::MS_PER_MIN))
                      ? 16'(h_r2 - 17'(tod_dly_pkg::MS_PER_MIN)) : h_r2[15:0];
      h_c3         <= (h_r3 >= 23'(tod_dly_pkg::MS_PER_HOUR))
                      ? 22'(h_r3 - 23'(tod_dly_pkg::MS_PER_HOUR)) : h_r3[21:0];
      h_c4         <= g_ms;
      delay_ms     <= delay_next;
    end
  end

  // An accepted beat lands in the input register
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted beat missing from input stage");

  // Pipeline freezes while the output beat is blocked
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(vld))
    else $error("pipeline moved while output blocked");

  // Day remainder is fully corrected
  assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (d_us < tod_dly_pkg::US_PER_DAY))
    else $error("microsecond of day out of range");

  // Millisecond of day is fully corrected
  assert property (@(posedge clk) disable iff (rst)
    vld[6] |-> (f_ms < tod_dly_pkg::MS_PER_DAY))
    else $error("millisecond of day out of range");

  // Sub-day positions stay inside their periods
  assert property (@(posedge clk) disable iff (rst)
    vld[8] |-> ((h_c1 < 10'(tod_dly_pkg::MS_PER_SEC))
             && (h_c2 < 16'(tod_dly_pkg::MS_PER_MIN))
             && (h_c3 < 22'(tod_dly_pkg::MS_PER_HOUR))))
    else $error("position within field out of range");

  // Delay is shorter than a day
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (delay_ms < tod_dly_pkg::MS_PER_DAY))
    else $error("delay out of range");

endmodule
